// ----- hw/rtl/qrm_pkg.sv -----
// qrm_pkg: shared types and constants for the quaternion to rotation matrix block
// used by qrm_div_pipe and quaternion_to_rotation_matrix_top; no dependencies
`timescale 1ns / 1ps

package qrm_pkg;

	// default number of fraction bits of the fixed point format
	localparam int FRAC_BITS_DEF = 14;

	// nine matrix entries per transaction
	localparam int NUM_ENT = 9;

	// squared norm is at most 2^32, numerator magnitudes never exceed it
	localparam int NORM_W = 33;
	// numerators before the magnitude step, signed
	localparam int NUM_W = 34;

	typedef struct packed {
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] col0_x;
		logic signed [15:0] col0_y;
		logic signed [15:0] col0_z;
		logic signed [15:0] col1_x;
		logic signed [15:0] col1_y;
		logic signed [15:0] col1_z;
		logic signed [15:0] col2_x;
		logic signed [15:0] col2_y;
		logic signed [15:0] col2_z;
	} mat_t;

endpackage

// ----- hw/rtl/qrm_div_pipe.sv -----
// qrm_div_pipe: pipelined restoring divider, nine lanes sharing one denominator
// one quotient bit per stage; depends on qrm_pkg
`timescale 1ns / 1ps

module qrm_div_pipe import qrm_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NORM_W-1:0] in_mag [NUM_ENT],
	input  logic              in_neg [NUM_ENT],
	input  logic [NORM_W-1:0] in_den,
	output logic              out_valid,
	output logic [FRACTION_BITS+1:0] out_quo [NUM_ENT],
	output logic              out_neg [NUM_ENT]
);

	// integer bit plus FRACTION_BITS+1 fraction bits (one extra for rounding)
	localparam int QW = FRACTION_BITS + 2;
	localparam int TW = NORM_W + 1;

	logic              vld_s [QW+1];
	logic [NORM_W-1:0] den_s [QW+1];
	logic [NORM_W-1:0] rem_s [QW+1][NUM_ENT];
	logic [QW-1:0]     quo_s [QW+1][NUM_ENT];
	logic              neg_s [QW+1][NUM_ENT];

	assign vld_s[0] = in_valid;
	assign den_s[0] = in_den;

	for (genvar e = 0; e < NUM_ENT; e++) begin : g_in
		assign rem_s[0][e] = in_mag[e];
		assign quo_s[0][e] = '0;
		assign neg_s[0][e] = in_neg[e];
	end

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [TW-1:0]     trial [NUM_ENT];
		logic              ge    [NUM_ENT];
		logic [NORM_W-1:0] rem_nx [NUM_ENT];

		for (genvar e = 0; e < NUM_ENT; e++) begin : g_lane
			always_comb begin
				// first step gives the integer bit, later steps shift the remainder
				if (k == 0) begin
					trial[e] = {1'b0, rem_s[k][e]};
				end else begin
					trial[e] = {rem_s[k][e], 1'b0};
				end
				ge[e] = trial[e] >= {1'b0, den_s[k]};
				if (ge[e]) begin
					rem_nx[e] = NORM_W'(trial[e] - {1'b0, den_s[k]});
				end else begin
					rem_nx[e] = NORM_W'(trial[e]);
				end
			end

			always_ff @(posedge clk) begin
				rem_s[k+1][e] <= rem_nx[e];
				quo_s[k+1][e] <= {quo_s[k][e][QW-2:0], ge[e]};
				neg_s[k+1][e] <= neg_s[k][e];
			end
		end

		always_ff @(posedge clk) begin
			den_s[k+1] <= den_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign out_valid = vld_s[QW];

	for (genvar e = 0; e < NUM_ENT; e++) begin : g_out
		assign out_quo[e] = quo_s[QW][e];
		assign out_neg[e] = neg_s[QW][e];
	end

endmodule

// ----- hw/rtl/quaternion_to_rotation_matrix_top.sv -----
// quaternion_to_rotation_matrix_top: quaternion to normalized 3x3 rotation matrix
// depends on qrm_pkg and qrm_div_pipe
`timescale 1ns / 1ps

// Usage:
//   A transaction enters when start is high; busy never rises, so the block
//   takes one quaternion every cycle. quat carries x, y, z, w as signed fixed
//   point with FRACTION_BITS fraction bits.
//   Each result appears on matrix for exactly one cycle with done high; the
//   nine entries are given column by column, each divided by the squared norm,
//   rounded to nearest (ties away from zero) and saturated to 16 bits.
//   A transaction passes through products, numerator sums, magnitude and
//   norm, then FRACTION_BITS + 2 divider stages of one quotient bit each,
//   then rounding and saturation. Throughput is one transaction per cycle.
//   A zero quaternion gives an all-zero matrix.
//   Reset clears the valid bits of every stage, so no done strobe follows it
//   until new transactions arrive. The receiver cannot stall: every result is
//   taken in the cycle it is shown.
module quaternion_to_rotation_matrix_top import qrm_pkg::*; #(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  quat_t quat,
	output logic  done,
	output mat_t  matrix
);

	localparam int QW = FRACTION_BITS + 2;
	localparam int CW = (QW > 17) ? QW : 17;

	assign busy = 1'b0;

	// stage 1: products
	logic               vld_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [31:0] xy_s1, xz_s1, yz_s1, xw_s1, yw_s1, zw_s1;

	always_ff @(posedge clk) begin
		xx_s1 <= quat.quat_x * quat.quat_x;
		yy_s1 <= quat.quat_y * quat.quat_y;
		zz_s1 <= quat.quat_z * quat.quat_z;
		ww_s1 <= quat.quat_w * quat.quat_w;
		xy_s1 <= quat.quat_x * quat.quat_y;
		xz_s1 <= quat.quat_x * quat.quat_z;
		yz_s1 <= quat.quat_y * quat.quat_z;
		xw_s1 <= quat.quat_x * quat.quat_w;
		yw_s1 <= quat.quat_y * quat.quat_w;
		zw_s1 <= quat.quat_z * quat.quat_w;
	end

	// stage 2: numerators and squared norm
	logic                    vld_s2;
	logic signed [NUM_W-1:0] num_s2 [NUM_ENT];
	logic [NORM_W-1:0]       norm_s2;

	logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, exw, eyw, ezw;

	always_comb begin
		exx = NUM_W'(xx_s1);
		eyy = NUM_W'(yy_s1);
		ezz = NUM_W'(zz_s1);
		eww = NUM_W'(ww_s1);
		exy = NUM_W'(xy_s1);
		exz = NUM_W'(xz_s1);
		eyz = NUM_W'(yz_s1);
		exw = NUM_W'(xw_s1);
		eyw = NUM_W'(yw_s1);
		ezw = NUM_W'(zw_s1);
	end

	always_ff @(posedge clk) begin
		num_s2[0] <= exx - eyy - ezz + eww;
		num_s2[1] <= (exy + ezw) <<< 1;
		num_s2[2] <= (exz - eyw) <<< 1;
		num_s2[3] <= (exy - ezw) <<< 1;
		num_s2[4] <= eww - exx + eyy - ezz;
		num_s2[5] <= (eyz + exw) <<< 1;
		num_s2[6] <= (exz + eyw) <<< 1;
		num_s2[7] <= (eyz - exw) <<< 1;
		num_s2[8] <= eww - exx - eyy + ezz;
		norm_s2   <= NORM_W'($unsigned(xx_s1)) + NORM_W'($unsigned(yy_s1))
		           + NORM_W'($unsigned(zz_s1)) + NORM_W'($unsigned(ww_s1));
	end

	// stage 3: sign and magnitude, zero norm taken as one
	logic              vld_s3;
	logic [NORM_W-1:0] mag_s3 [NUM_ENT];
	logic              neg_s3 [NUM_ENT];
	logic [NORM_W-1:0] den_s3;

	always_ff @(posedge clk) begin
		for (int e = 0; e < NUM_ENT; e++) begin
			neg_s3[e] <= num_s2[e][NUM_W-1];
			if (num_s2[e][NUM_W-1]) begin
				mag_s3[e] <= NORM_W'(-num_s2[e]);
			end else begin
				mag_s3[e] <= NORM_W'(num_s2[e]);
			end
		end
		if (norm_s2 == '0) begin
			den_s3 <= NORM_W'(1);
		end else begin
			den_s3 <= norm_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// divider: floor(mag * 2^(FRACTION_BITS+1) / den)
	logic          div_vld;
	logic [QW-1:0] div_quo [NUM_ENT];
	logic          div_neg [NUM_ENT];

	qrm_div_pipe #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s3),
		.in_mag   (mag_s3),
		.in_neg   (neg_s3),
		.in_den   (den_s3),
		.out_valid(div_vld),
		.out_quo  (div_quo),
		.out_neg  (div_neg)
	);

	// rounding: (q0 + 1) >> 1 gives round half up of the magnitude
	logic [QW:0]        rnd_sum [NUM_ENT];
	logic [CW-1:0]      rnd_mag [NUM_ENT];
	logic signed [15:0] ent     [NUM_ENT];

	always_comb begin
		for (int e = 0; e < NUM_ENT; e++) begin
			rnd_sum[e] = {1'b0, div_quo[e]} + (QW+1)'(1);
			rnd_mag[e] = CW'(rnd_sum[e][QW:1]);
			if (div_neg[e]) begin
				if (rnd_mag[e] > CW'(32768)) begin
					ent[e] = 16'sh8000;
				end else begin
					ent[e] = 16'(~rnd_mag[e] + CW'(1));
				end
			end else begin
				if (rnd_mag[e] > CW'(32767)) begin
					ent[e] = 16'sh7fff;
				end else begin
					ent[e] = 16'(rnd_mag[e]);
				end
			end
		end
	end

	logic done_q;
	mat_t mat_q;

	always_ff @(posedge clk) begin
		mat_q.col0_x <= ent[0];
		mat_q.col0_y <= ent[1];
		mat_q.col0_z <= ent[2];
		mat_q.col1_x <= ent[3];
		mat_q.col1_y <= ent[4];
		mat_q.col1_z <= ent[5];
		mat_q.col2_x <= ent[6];
		mat_q.col2_y <= ent[7];
		mat_q.col2_z <= ent[8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	assign done   = done_q;
	assign matrix = mat_q;

endmodule

// ----- dv/tb_quaternion_to_rotation_matrix_top.sv -----
// tb_quaternion_to_rotation_matrix_top: self-checking bench for the quaternion to matrix block
// directed table, then random quaternions, results scored against table expectations or a local predictor
// depends on qrm_pkg and quaternion_to_rotation_matrix_top
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_top;
	import qrm_pkg::*;

	localparam int FRACTION_BITS = FRAC_BITS_DEF;
	localparam int LATENCY = FRACTION_BITS + 6;
	localparam int RAND_ITEMS = 1500;
	localparam int CALM_TAIL = 200;
	localparam int STALL_LIMIT = 400;
	localparam int MAX_PRINTS = 100;

	localparam logic signed [15:0] ONE = 16'sd1 <<< FRACTION_BITS;
	localparam logic signed [15:0] NEG_ONE = -ONE;
	localparam logic signed [15:0] Q_MAX = 16'sh7fff;
	localparam logic signed [15:0] Q_MIN = 16'sh8000;

	localparam mat_t MAT_ZERO = '0;
	localparam mat_t MAT_IDENT = '{col0_x: ONE, col1_y: ONE, col2_z: ONE, default: '0};
	// half turns about one axis
	localparam mat_t MAT_TURN_X = '{col0_x: ONE, col1_y: NEG_ONE, col2_z: NEG_ONE,
		default: '0};
	localparam mat_t MAT_TURN_Y = '{col0_x: NEG_ONE, col1_y: ONE, col2_z: NEG_ONE,
		default: '0};
	localparam mat_t MAT_TURN_Z = '{col0_x: NEG_ONE, col1_y: NEG_ONE, col2_z: ONE,
		default: '0};

	typedef struct {
		quat_t q;
		bit    known;
		mat_t  m;
	} quat_row_t;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	quat_t quat;
	logic  done;
	mat_t  matrix;

	// typed expectation riding along with the quaternion for directed rows
	logic  known_valid;
	mat_t  known_mat;

	// newest expectation at the front, oldest at the back
	mat_t  pending_mats[$];
	int    mismatch_cnt;
	int    stall_cycles;

	string entry_names[9] = '{"col0_x", "col0_y", "col0_z", "col1_x", "col1_y",
		"col1_z", "col2_x", "col2_y", "col2_z"};

	quaternion_to_rotation_matrix_top #(
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.quat(quat),
		.done(done),
		.matrix(matrix)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// round(num * 2^F / den), ties away from zero, saturated to 16 bits
	function automatic logic signed [15:0] scale_entry(longint num, longint den);
		longint mag;
		longint qv;
		mag = (num < 0) ? -num : num;
		qv = ((mag <<< FRACTION_BITS) + (den >>> 1)) / den;
		if (num < 0) begin
			return (qv > 32768) ? Q_MIN : 16'(-qv);
		end
		return (qv > 32767) ? Q_MAX : 16'(qv);
	endfunction

	function automatic mat_t predict_rotation(quat_t q);
		longint x, y, z, w, n;
		mat_t m;
		x = $signed(q.quat_x);
		y = $signed(q.quat_y);
		z = $signed(q.quat_z);
		w = $signed(q.quat_w);
		n = x * x + y * y + z * z + w * w;
		if (n == 0) begin
			n = 1;
		end
		m.col0_x = scale_entry(x * x - y * y - z * z + w * w, n);
		m.col0_y = scale_entry(2 * (x * y + z * w), n);
		m.col0_z = scale_entry(2 * (x * z - y * w), n);
		m.col1_x = scale_entry(2 * (x * y - z * w), n);
		m.col1_y = scale_entry(-x * x + y * y - z * z + w * w, n);
		m.col1_z = scale_entry(2 * (y * z + x * w), n);
		m.col2_x = scale_entry(2 * (x * z + y * w), n);
		m.col2_y = scale_entry(2 * (y * z - x * w), n);
		m.col2_z = scale_entry(-x * x - y * y + z * z + w * w, n);
		return m;
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= MAX_PRINTS) begin
			$display("%0t ERROR: %s", $realtime, msg);
		end
	endtask

	// scoreboard: inputs and results both sampled at the rising edge
	always @(posedge clk) begin
		mat_t want;
		bit   active;
		active = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				pending_mats.push_front(known_valid ? known_mat : predict_rotation(quat));
				active = 1'b1;
			end
			if (done) begin
				active = 1'b1;
				if (pending_mats.size() == 0) begin
					report_mismatch($sformatf("unexpected matrix %h", matrix));
				end else begin
					want = pending_mats.pop_back();
					for (int k = 0; k < NUM_ENT; k++) begin
						if (matrix[(8 - k) * 16 +: 16] !== want[(8 - k) * 16 +: 16]) begin
							report_mismatch($sformatf("%s got %0d want %0d",
								entry_names[k], $signed(matrix[(8 - k) * 16 +: 16]),
								$signed(want[(8 - k) * 16 +: 16])));
						end
					end
				end
			end
		end
		stall_cycles <= active ? 0 : stall_cycles + 1;
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic drive_quat(quat_t q, bit known, mat_t m);
		@(negedge clk);
		start <= 1'b1;
		quat <= q;
		known_valid <= known;
		known_mat <= m;
		do @(posedge clk); while (busy);
	endtask

	task automatic hold_start_low(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_matrices_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_mats.size() != 0) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_component(int unsigned mode);
		logic signed [15:0] corners[7] = '{16'sd0, 16'sd1, -16'sd1, Q_MAX, Q_MIN,
			ONE, NEG_ONE};
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 16)) - 16'sd8;
			2: return corners[$urandom_range(0, 6)];
			default: return 16'($urandom_range(0, 4095)) - 16'sd2048;
		endcase
	endfunction

	function automatic quat_t rand_quat();
		quat_t q;
		int unsigned kind;
		int unsigned axis;
		kind = $urandom_range(0, 9);
		q.quat_x = rand_component(kind <= 4 ? 0 : kind <= 6 ? 1 : kind == 7 ? 2 :
			$urandom_range(0, 3));
		q.quat_y = rand_component(kind <= 4 ? 0 : kind <= 6 ? 1 : kind == 7 ? 2 :
			$urandom_range(0, 3));
		q.quat_z = rand_component(kind <= 4 ? 0 : kind <= 6 ? 1 : kind == 7 ? 2 :
			$urandom_range(0, 3));
		q.quat_w = rand_component(kind <= 4 ? 0 : kind <= 6 ? 1 : kind == 7 ? 2 :
			$urandom_range(0, 3));
		// pure single-axis quaternion with random magnitude
		if (kind == 8) begin
			axis = $urandom_range(0, 3);
			q = '0;
			case (axis)
				0: q.quat_x = 16'($urandom);
				1: q.quat_y = 16'($urandom);
				2: q.quat_z = 16'($urandom);
				default: q.quat_w = 16'($urandom);
			endcase
		end
		return q;
	endfunction

	initial begin
		// rows enter at the front and are walked from the back, in listed order
		quat_row_t rows[$];
		quat_row_t row;
		start = 1'b0;
		quat = '0;
		known_valid = 1'b0;
		known_mat = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero quaternion, identities at several scales, half turns at several scales including the extremes
		rows.push_front('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, MAT_ZERO});
		rows.push_front('{'{16'sd0, 16'sd0, 16'sd0, ONE}, 1'b1, MAT_IDENT});
		rows.push_front('{'{16'sd0, 16'sd0, 16'sd0, Q_MIN}, 1'b1, MAT_IDENT});
		rows.push_front('{'{16'sd0, 16'sd0, 16'sd0, Q_MAX}, 1'b1, MAT_IDENT});
		rows.push_front('{'{16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b1, MAT_IDENT});
		rows.push_front('{'{ONE, 16'sd0, 16'sd0, 16'sd0}, 1'b1, MAT_TURN_X});
		rows.push_front('{'{Q_MIN, 16'sd0, 16'sd0, 16'sd0}, 1'b1, MAT_TURN_X});
		rows.push_front('{'{16'sd0, Q_MAX, 16'sd0, 16'sd0}, 1'b1, MAT_TURN_Y});
		rows.push_front('{'{16'sd0, NEG_ONE, 16'sd0, 16'sd0}, 1'b1, MAT_TURN_Y});
		rows.push_front('{'{16'sd0, 16'sd0, -16'sd1, 16'sd0}, 1'b1, MAT_TURN_Z});
		rows.push_front('{'{16'sd0, 16'sd0, Q_MIN, 16'sd0}, 1'b1, MAT_TURN_Z});
		// the rest go through the predictor
		rows.push_front('{'{Q_MIN, Q_MIN, Q_MIN, Q_MIN}, 1'b0, MAT_ZERO});
		rows.push_front('{'{Q_MAX, Q_MAX, Q_MAX, Q_MAX}, 1'b0, MAT_ZERO});
		rows.push_front('{'{Q_MAX, Q_MIN, Q_MAX, Q_MIN}, 1'b0, MAT_ZERO});
		rows.push_front('{'{Q_MIN, Q_MAX, Q_MIN, Q_MAX}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sd1, 16'sd2, 16'sd3, 16'sd4}, 1'b0, MAT_ZERO});
		rows.push_front('{'{-16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sd11585, 16'sd0, 16'sd0, 16'sd11585}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sd1, 16'sd1, 16'sd0, 16'sd1}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sd3, 16'sd0, 16'sd0, -16'sd1}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa}, 1'b0, MAT_ZERO});
		rows.push_front('{'{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555}, 1'b0, MAT_ZERO});

		while (rows.size() != 0) begin
			row = rows.pop_back();
			if ($urandom_range(0, 3) == 0) begin
				hold_start_low($urandom_range(1, 4));
			end
			drive_quat(row.q, row.known, row.m);
		end

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 2) begin
				wait_matrices_drained();
			end
			if (i < RAND_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				hold_start_low($urandom_range(1, 4));
			end
			drive_quat(rand_quat(), 1'b0, MAT_ZERO);
		end

		wait_matrices_drained();
		// catch any stray strobe after the last result
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
